// File: sv/cpurf_pkg.sv
package cpurf_pkg;

   typedef enum logic [3:0] {
      ACT_WR_BYTE    = 4'd0,
      ACT_RD_BYTE    = 4'd1,
      ACT_WR_PAIR    = 4'd2,
      ACT_RD_PAIR    = 4'd3,
      ACT_WR_SPECIAL = 4'd4,
      ACT_RD_SPECIAL = 4'd5,
      ACT_SET_FLAGS  = 4'd6,
      ACT_CLR_FLAGS  = 4'd7,
      ACT_STEP_PC    = 4'd8,
      ACT_SP_DOWN    = 4'd9,
      ACT_SP_UP      = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADSEL = 2'd1,
      ST_FAULT  = 2'd2
   } status_type;

   // byte register numbers
   localparam logic [2:0] REG_A = 3'd0;
   localparam logic [2:0] REG_B = 3'd1;
   localparam logic [2:0] REG_C = 3'd2;
   localparam logic [2:0] REG_D = 3'd3;
   localparam logic [2:0] REG_E = 3'd4;
   localparam logic [2:0] REG_H = 3'd5;
   localparam logic [2:0] REG_L = 3'd6;

   // pair selectors
   localparam logic [2:0] PAIR_AF = 3'd0;
   localparam logic [2:0] PAIR_BC = 3'd1;
   localparam logic [2:0] PAIR_DE = 3'd2;
   localparam logic [2:0] PAIR_HL = 3'd3;

   // special register selectors
   localparam logic [2:0] SPC_IX = 3'd0;
   localparam logic [2:0] SPC_IY = 3'd1;
   localparam logic [2:0] SPC_SP = 3'd2;
   localparam logic [2:0] SPC_PC = 3'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_PROGRAM_END = 2'd0;
   localparam logic [1:0] CSR_STACK_FLOOR = 2'd1;

   typedef struct packed {
      action_type  action;
      logic [2:0]  reg_sel;
      logic [15:0] data;
   } req_type;

   typedef struct packed {
      logic [15:0] read_data;
      status_type  status;
   } rsp_type;

endpackage

// File: sv/cpu_register_file_with_pairs.sv
// Channel   Ports                               Direction  Handshake
// request   start, busy, req_payload            in         accepted when start && !busy
// response  rsp_valid, rsp_payload              out        one-cycle strobe, no back-pressure
// csr       csr_we, csr_index, csr_wdata        in         written when csr_we
//
// From acceptance to the rsp_valid strobe there is one input register, then one result
// register, with the register update at the same edge as the result.
// One transaction is taken every cycle while busy is low; busy is set in reset, cleared after it.
// Reset clears all byte registers, flags, IX, IY, SP, PC and both csr values.
// The receiver cannot stall, so nothing ever backs up inside the block.
module cpu_register_file_with_pairs
   import cpurf_pkg::*;
#(
   parameter int NUM_BYTE_REGS = 7,
   parameter int MEM_SIZE      = 65535
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_payload,
   output logic        rsp_valid,
   output rsp_type     rsp_payload,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic          busy_ff;
   logic          req_valid_ff;
   req_type       req_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;
   rsp_type       rsp_in;

   logic [7:0]    byte_regs_ff [NUM_BYTE_REGS];
   logic [7:0]    byte_regs_in [NUM_BYTE_REGS];
   logic [7:0]    flags_ff, flags_in;
   logic [15:0]   ix_ff, ix_in;
   logic [15:0]   iy_ff, iy_in;
   logic [15:0]   sp_ff, sp_in;
   logic [15:0]   pc_ff, pc_in;
   logic [15:0]   program_end_ff;
   logic [15:0]   stack_floor_ff;

   logic          byte_sel_ok;
   logic          pc_past_end;
   logic          sp_at_floor;
   logic          sp_at_top;

   assign busy        = busy_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign byte_sel_ok = {1'b0, req_ff.reg_sel} < 4'(NUM_BYTE_REGS);
   assign pc_past_end = pc_ff > program_end_ff;
   assign sp_at_floor = sp_ff <= stack_floor_ff;
   assign sp_at_top   = {1'b0, sp_ff} >= 17'(MEM_SIZE);

   always_comb begin
      byte_regs_in = byte_regs_ff;
      flags_in     = flags_ff;
      ix_in        = ix_ff;
      iy_in        = iy_ff;
      sp_in        = sp_ff;
      pc_in        = pc_ff;
      rsp_in       = '{read_data: 16'd0, status: ST_OK};

      case (req_ff.action)
         ACT_WR_BYTE: begin
            if (byte_sel_ok) begin
               for (int i = 0; i < NUM_BYTE_REGS; i++) begin
                  if (req_ff.reg_sel == 3'(i)) begin
                     byte_regs_in[i] = req_ff.data[7:0];
                  end
               end
            end else begin
               rsp_in.status = ST_BADSEL;
            end
         end
         ACT_RD_BYTE: begin
            if (byte_sel_ok) begin
               for (int i = 0; i < NUM_BYTE_REGS; i++) begin
                  if (req_ff.reg_sel == 3'(i)) begin
                     rsp_in.read_data = {8'd0, byte_regs_ff[i]};
                  end
               end
            end else begin
               rsp_in.status = ST_BADSEL;
            end
         end
         ACT_WR_PAIR: begin
            case (req_ff.reg_sel)
               PAIR_AF: ;  // AF is read-only through this path
               PAIR_BC: begin
                  byte_regs_in[REG_B] = req_ff.data[15:8];
                  byte_regs_in[REG_C] = req_ff.data[7:0];
               end
               PAIR_DE: begin
                  byte_regs_in[REG_D] = req_ff.data[15:8];
                  byte_regs_in[REG_E] = req_ff.data[7:0];
               end
               PAIR_HL: begin
                  byte_regs_in[REG_H] = req_ff.data[15:8];
                  byte_regs_in[REG_L] = req_ff.data[7:0];
               end
               default: rsp_in.status = ST_BADSEL;
            endcase
         end
         ACT_RD_PAIR: begin
            case (req_ff.reg_sel)
               PAIR_AF: rsp_in.read_data = {byte_regs_ff[REG_A], flags_ff};
               PAIR_BC: rsp_in.read_data = {byte_regs_ff[REG_B], byte_regs_ff[REG_C]};
               PAIR_DE: rsp_in.read_data = {byte_regs_ff[REG_D], byte_regs_ff[REG_E]};
               PAIR_HL: rsp_in.read_data = {byte_regs_ff[REG_H], byte_regs_ff[REG_L]};
               default: rsp_in.status = ST_BADSEL;
            endcase
         end
         ACT_WR_SPECIAL: begin
            case (req_ff.reg_sel)
               SPC_IX:  ix_in = req_ff.data;
               SPC_IY:  iy_in = req_ff.data;
               SPC_SP:  sp_in = req_ff.data;
               SPC_PC:  pc_in = req_ff.data;
               default: rsp_in.status = ST_BADSEL;
            endcase
         end
         ACT_RD_SPECIAL: begin
            case (req_ff.reg_sel)
               SPC_IX:  rsp_in.read_data = ix_ff;
               SPC_IY:  rsp_in.read_data = iy_ff;
               SPC_SP:  rsp_in.read_data = sp_ff;
               SPC_PC:  rsp_in.read_data = pc_ff;
               default: rsp_in.status = ST_BADSEL;
            endcase
         end
         ACT_SET_FLAGS: flags_in = flags_ff | req_ff.data[7:0];
         ACT_CLR_FLAGS: flags_in = flags_ff & ~req_ff.data[7:0];
         ACT_STEP_PC: begin
            if (pc_past_end) rsp_in.status = ST_FAULT;
            else             pc_in = pc_ff + 16'd1;
         end
         ACT_SP_DOWN: begin
            if (sp_at_floor) rsp_in.status = ST_FAULT;
            else             sp_in = sp_ff - 16'd1;
         end
         ACT_SP_UP: begin
            if (sp_at_top) rsp_in.status = ST_FAULT;
            else           sp_in = sp_ff + 16'd1;
         end
         default: rsp_in.status = ST_BADSEL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff        <= 1'b1;
         req_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         flags_ff       <= 8'd0;
         ix_ff          <= 16'd0;
         iy_ff          <= 16'd0;
         sp_ff          <= 16'd0;
         pc_ff          <= 16'd0;
         program_end_ff <= 16'd0;
         stack_floor_ff <= 16'd0;
         for (int i = 0; i < NUM_BYTE_REGS; i++) begin
            byte_regs_ff[i] <= 8'd0;
         end
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            flags_ff     <= flags_in;
            ix_ff        <= ix_in;
            iy_ff        <= iy_in;
            sp_ff        <= sp_in;
            pc_ff        <= pc_in;
            byte_regs_ff <= byte_regs_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PROGRAM_END: program_end_ff <= csr_wdata;
               CSR_STACK_FLOOR: stack_floor_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      req_ff <= req_payload;
      rsp_ff <= rsp_in;
   end

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("response strobe missing two cycles after a transaction");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_OK) |-> rsp_payload.read_data == 16'd0)
      else $error("error response carries nonzero read data");

   a_pc_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && req_ff.action == ACT_STEP_PC && !pc_past_end)
      |=> pc_ff == $past(pc_ff) + 16'd1)
      else $error("PC did not advance by one");

   a_sp_idle: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |=> $stable(sp_ff))
      else $error("SP changed with no transaction in flight");

   a_sp_fault: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && req_ff.action == ACT_SP_DOWN && sp_at_floor)
      |=> rsp_payload.status == ST_FAULT && $stable(sp_ff))
      else $error("SP decrement at floor not faulted");

endmodule

// File: test/testbench.sv
module testbench;
   import cpurf_pkg::*;

   localparam int NUM_BYTE_REGS   = 7;
   localparam int MEM_SIZE        = 65535;
   localparam int STALL_LIMIT     = 400;
   localparam int ITEMS_PER_PHASE = 84;

   // action codes the block does not define
   localparam logic [3:0] ACT_UNUSED_LO = 4'd11;
   localparam logic [3:0] ACT_UNUSED_HI = 4'd15;
   // first selector past the pair and special ranges, and the top selector
   localparam logic [2:0] SEL_PAST_SPC = 3'd4;
   localparam logic [2:0] SEL_TOP      = 3'd7;
   // csr indexes with no register behind them
   localparam logic [1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [1:0] CSR_SPARE_HI = 2'd3;

   class regfile_scoreboard;
      logic [7:0]  regs [NUM_BYTE_REGS];
      logic [7:0]  flags;
      logic [15:0] ix, iy, sp, pc;
      logic [15:0] prog_end, stack_floor;
      rsp_type     expected_q [$];
      int          errors, checked, faults, badsels;

      function new();
         foreach (regs[i]) regs[i] = '0;
         flags = '0;
         ix = '0;
         iy = '0;
         sp = '0;
         pc = '0;
         prog_end = '0;
         stack_floor = '0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void set_csr(input logic [1:0] idx, input logic [15:0] val);
         case (idx)
            CSR_PROGRAM_END: prog_end = val;
            CSR_STACK_FLOOR: stack_floor = val;
            default: ;
         endcase
      endfunction

      // apply one accepted transaction to the shadow registers, queue its result
      function void note_request(input req_type r);
         rsp_type want;
         int      hi, lo;
         want.read_data = '0;
         want.status = ST_OK;
         hi = 2 * int'(r.reg_sel) - 1;
         lo = 2 * int'(r.reg_sel);
         case (r.action)
            ACT_WR_BYTE: begin
               if (r.reg_sel < NUM_BYTE_REGS) regs[r.reg_sel] = r.data[7:0];
               else want.status = ST_BADSEL;
            end
            ACT_RD_BYTE: begin
               if (r.reg_sel < NUM_BYTE_REGS) want.read_data = {8'h00, regs[r.reg_sel]};
               else want.status = ST_BADSEL;
            end
            ACT_WR_PAIR: begin
               if (r.reg_sel > PAIR_HL) begin
                  want.status = ST_BADSEL;
               end else if (r.reg_sel != PAIR_AF) begin
                  regs[hi] = r.data[15:8];
                  regs[lo] = r.data[7:0];
               end
            end
            ACT_RD_PAIR: begin
               if (r.reg_sel > PAIR_HL) want.status = ST_BADSEL;
               else if (r.reg_sel == PAIR_AF) want.read_data = {regs[REG_A], flags};
               else want.read_data = {regs[hi], regs[lo]};
            end
            ACT_WR_SPECIAL: begin
               case (r.reg_sel)
                  SPC_IX: ix = r.data;
                  SPC_IY: iy = r.data;
                  SPC_SP: sp = r.data;
                  SPC_PC: pc = r.data;
                  default: want.status = ST_BADSEL;
               endcase
            end
            ACT_RD_SPECIAL: begin
               case (r.reg_sel)
                  SPC_IX: want.read_data = ix;
                  SPC_IY: want.read_data = iy;
                  SPC_SP: want.read_data = sp;
                  SPC_PC: want.read_data = pc;
                  default: want.status = ST_BADSEL;
               endcase
            end
            ACT_SET_FLAGS: flags = flags | r.data[7:0];
            ACT_CLR_FLAGS: flags = flags & ~r.data[7:0];
            ACT_STEP_PC: begin
               if (pc > prog_end) want.status = ST_FAULT;
               else pc = pc + 16'd1;
            end
            ACT_SP_DOWN: begin
               if (sp <= stack_floor) want.status = ST_FAULT;
               else sp = sp - 16'd1;
            end
            ACT_SP_UP: begin
               if (int'(sp) >= MEM_SIZE) want.status = ST_FAULT;
               else sp = sp + 16'd1;
            end
            default: want.status = ST_BADSEL;
         endcase
         if (want.status == ST_FAULT) faults++;
         if (want.status == ST_BADSEL) badsels++;
         expected_q.push_back(want);
      endfunction

      task report(input string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing outstanding: data %h status %0d",
                             got.read_data, got.status));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.read_data !== want.read_data)
            report($sformatf("result %0d read_data %h, expected %h",
                             checked, got.read_data, want.read_data));
         if (got.status !== want.status)
            report($sformatf("result %0d status %0d, expected %0d",
                             checked, got.status, want.status));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_valid;
   rsp_type     rsp_payload;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   regfile_scoreboard sb = new();
   int items_sent   = 0;
   int phases_run   = 0;
   int stall_cycles = 0;
   bit idling_on    = 1'b0;

   cpu_register_file_with_pairs #(
      .NUM_BYTE_REGS(NUM_BYTE_REGS),
      .MEM_SIZE     (MEM_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) sb.set_csr(csr_index, csr_wdata);
         if (rsp_valid) sb.check_response(rsp_payload);
         if (start && !busy) sb.note_request(req_payload);
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_we) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic req_type make_req(input action_type act, input logic [2:0] sel,
                                        input logic [15:0] value);
      req_type r;
      r.action = act;
      r.reg_sel = sel;
      r.data = value;
      return r;
   endfunction

   function automatic logic [15:0] near_value(input logic [15:0] v);
      return v + 16'($urandom_range(0, 6)) - 16'd3;
   endfunction

   function automatic req_type random_req();
      req_type r;
      if ($urandom_range(0, 19) == 0)
         r.action = action_type'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      else
         r.action = action_type'($urandom_range(ACT_WR_BYTE, ACT_SP_UP));
      if ($urandom_range(0, 9) == 0)
         r.reg_sel = 3'($urandom_range(0, 7));
      else if (r.action == ACT_WR_BYTE || r.action == ACT_RD_BYTE)
         r.reg_sel = 3'($urandom_range(REG_A, REG_L));
      else
         r.reg_sel = 3'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
         0: r.data = 16'hFFFF;
         1: r.data = 16'h0000;
         2: r.data = near_value(sb.prog_end);
         3: r.data = near_value(sb.stack_floor);
         default: r.data = 16'($urandom);
      endcase
      return r;
   endfunction

   task automatic send(input req_type r);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
   endtask

   // park PC or SP next to a limit, then step it across
   task automatic boundary_run();
      int steps;
      int kind;
      steps = $urandom_range(2, 6);
      kind = $urandom_range(0, 2);
      case (kind)
         0: send(make_req(ACT_WR_SPECIAL, SPC_PC, near_value(sb.prog_end)));
         1: send(make_req(ACT_WR_SPECIAL, SPC_SP, near_value(sb.stack_floor)));
         default: send(make_req(ACT_WR_SPECIAL, SPC_SP, 16'hFFFF - 16'($urandom_range(0, 4))));
      endcase
      repeat (steps) begin
         case (kind)
            0: send(make_req(ACT_STEP_PC, 3'($urandom_range(0, 7)), 16'($urandom)));
            1: send(make_req(ACT_SP_DOWN, 3'($urandom_range(0, 7)), 16'($urandom)));
            default: send(make_req(ACT_SP_UP, 3'($urandom_range(0, 7)), 16'($urandom)));
         endcase
      end
      send(make_req(ACT_RD_SPECIAL, (kind == 0) ? SPC_PC : SPC_SP, 16'($urandom)));
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_limits(input logic [15:0] pe, input logic [15:0] sf, input bit spare);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_PROGRAM_END;
      csr_wdata <= pe;
      @(posedge clock);
      csr_index <= CSR_STACK_FLOOR;
      csr_wdata <= sf;
      @(posedge clock);
      if (spare) begin
         csr_index <= $urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI;
         csr_wdata <= 16'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      phases_run++;
   endtask

   initial begin
      logic [15:0] end_set   [5];
      logic [15:0] floor_set [5];
      int          target;
      end_set   = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom)};
      floor_set = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'($urandom), 16'($urandom)};
      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      csr_we <= 1'b0;
      csr_index <= CSR_PROGRAM_END;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // limits still at reset: PC may step once, SP sits on the floor
      send(make_req(ACT_SP_DOWN, SEL_TOP, 16'h0000));
      send(make_req(ACT_STEP_PC, REG_A, 16'hFFFF));
      send(make_req(ACT_STEP_PC, REG_A, 16'h0000));
      send(make_req(ACT_SP_UP, REG_L, 16'h1234));
      send(make_req(ACT_WR_BYTE, REG_A, 16'h12FF));
      send(make_req(ACT_WR_BYTE, REG_L, 16'hFF00));
      send(make_req(ACT_WR_BYTE, SEL_TOP, 16'hFFFF));
      send(make_req(ACT_RD_BYTE, REG_A, 16'h0000));
      send(make_req(ACT_RD_BYTE, SEL_TOP, 16'h0000));
      send(make_req(ACT_WR_PAIR, PAIR_AF, 16'hFFFF));
      send(make_req(ACT_SET_FLAGS, SEL_TOP, 16'hFFA5));
      send(make_req(ACT_CLR_FLAGS, REG_A, 16'hFF21));
      send(make_req(ACT_RD_PAIR, PAIR_AF, 16'h0000));
      send(make_req(ACT_WR_PAIR, PAIR_HL, 16'hFFFF));
      send(make_req(ACT_WR_PAIR, PAIR_BC, 16'h8001));
      send(make_req(ACT_RD_PAIR, PAIR_HL, 16'h0000));
      send(make_req(ACT_RD_PAIR, PAIR_BC, 16'h0000));
      send(make_req(ACT_WR_PAIR, SEL_PAST_SPC, 16'h5555));
      send(make_req(ACT_RD_PAIR, SEL_TOP, 16'h0000));
      send(make_req(ACT_WR_SPECIAL, SPC_IX, 16'hFFFF));
      send(make_req(ACT_WR_SPECIAL, SPC_SP, 16'hFFFF));
      send(make_req(ACT_SP_UP, REG_A, 16'h0000));
      send(make_req(ACT_SP_DOWN, REG_A, 16'h0000));
      send(make_req(ACT_RD_SPECIAL, SPC_SP, 16'h0000));
      send(make_req(ACT_RD_SPECIAL, SEL_PAST_SPC, 16'h0000));
      send(make_req(ACT_WR_SPECIAL, SEL_TOP, 16'hAAAA));
      send(make_req(action_type'(ACT_UNUSED_LO), REG_B, 16'hFFFF));
      send(make_req(action_type'(ACT_UNUSED_HI), SEL_TOP, 16'hFFFF));

      for (int p = 0; p < 5; p++) begin
         set_limits(end_set[p], floor_set[p], p == 0);
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            // switch idling on and off in stretches; none in the last phase
            if (p == 4 || items_sent % 30 == 0)
               idling_on = (p != 4) && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 6) == 0) boundary_run();
            else send(random_req());
         end
      end
      drain();

      $display("covered %0d transactions over %0d limit settings, %0d results checked",
               items_sent, phases_run, sb.checked);
      $display("status mix: %0d bounds faults, %0d bad selectors or actions",
               sb.faults, sb.badsels);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
